// ===== rtl/rroc_pkg.sv =====
// ----------------------------------------------------------------------------
// rroc_pkg
// Shared types and constants of the region range overlap checker: status
// codes, register indexes, store sizing and the stored range entry.
// ----------------------------------------------------------------------------
package rroc_pkg;

  // store sizing
  localparam int unsigned MaxRanges = 256;
  localparam int unsigned AddrW     = $clog2(MaxRanges);
  localparam int unsigned CountW    = $clog2(MaxRanges + 1);

  // field widths
  localparam int unsigned DataW   = 64;
  localparam int unsigned StatusW = 4;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_REGION_START = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_REGION_END   = 2'd1;

  // status codes
  localparam logic [StatusW-1:0] ST_OK            = 4'd0;
  localparam logic [StatusW-1:0] ST_FRAME_BELOW   = 4'd1;
  localparam logic [StatusW-1:0] ST_FRAME_OVFL    = 4'd2;
  localparam logic [StatusW-1:0] ST_FRAME_PAST    = 4'd3;
  localparam logic [StatusW-1:0] ST_SEG_BELOW     = 4'd4;
  localparam logic [StatusW-1:0] ST_SEG_OVFL      = 4'd5;
  localparam logic [StatusW-1:0] ST_SEG_PAST      = 4'd6;
  localparam logic [StatusW-1:0] ST_FRAME_OVERLAP = 4'd7;
  localparam logic [StatusW-1:0] ST_SEG_OVERLAP   = 4'd8;
  localparam logic [StatusW-1:0] ST_MIXED_OVERLAP = 4'd9;
  localparam logic [StatusW-1:0] ST_TOO_MANY      = 4'd10;

  // shared adder operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // adder result: carry out is the inverted borrow for a subtract
  typedef struct packed {
    logic             carry;
    logic [DataW-1:0] sum;
  } alu_res_t;

  // one stored range
  typedef struct packed {
    logic [DataW-1:0] start;
    logic [DataW-1:0] lim;
    logic             kind;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

// ===== rtl/rroc_if.sv =====
// ----------------------------------------------------------------------------
// rroc_if
// Valid/ready channels of the checker: the range input and the status output.
// ----------------------------------------------------------------------------
interface rroc_range_if;
  logic                        valid;
  logic                        ready;
  logic [rroc_pkg::DataW-1:0]  range_offset;
  logic [rroc_pkg::DataW-1:0]  range_length;
  logic                        range_kind;
  logic                        last_range;

  modport source (
    output valid, range_offset, range_length, range_kind, last_range,
    input  ready
  );
  modport sink (
    input  valid, range_offset, range_length, range_kind, last_range,
    output ready
  );
endinterface

interface rroc_status_if;
  logic                         valid;
  logic                         ready;
  logic [rroc_pkg::StatusW-1:0] status;

  modport source (
    output valid, status,
    input  ready
  );
  modport sink (
    input  valid, status,
    output ready
  );
endinterface

// ===== rtl/rroc_ram.sv =====
// ----------------------------------------------------------------------------
// rroc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module rroc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rroc_alu.sv =====
// ----------------------------------------------------------------------------
// rroc_alu
// Shared 64-bit adder: add for the range end, subtract for every magnitude
// compare (x < y when the subtract gives no carry).
// ----------------------------------------------------------------------------
module rroc_alu (
  input  rroc_pkg::alu_op_e               op_i,
  input  logic [rroc_pkg::DataW-1:0]      x_i,
  input  logic [rroc_pkg::DataW-1:0]      y_i,
  output rroc_pkg::alu_res_t              res_o
);

  logic                         inv;
  logic [rroc_pkg::DataW-1:0]   y_eff;
  logic [rroc_pkg::DataW:0]     total;

  // x + y, or x + ~y + 1 for a subtract
  assign inv   = (op_i == rroc_pkg::ALU_SUB);
  assign y_eff = inv ? ~y_i : y_i;
  assign total = {1'b0, x_i} + {1'b0, y_eff} + {{rroc_pkg::DataW{1'b0}}, inv};

  assign res_o.carry = total[rroc_pkg::DataW];
  assign res_o.sum   = total[rroc_pkg::DataW-1:0];

endmodule

// ===== rtl/region_range_overlap_checker.sv =====
// ----------------------------------------------------------------------------
// region_range_overlap_checker
// Checks byte ranges against a data region, keeps them sorted by start and
// reports bounds errors or neighbor overlap when a set is closed.
// ----------------------------------------------------------------------------
// Usage: ranges enter one beat at a time on range_i (valid/ready). A beat
// with last_range set closes the set; one status beat then leaves on
// status_o. Other beats give no output. The user must write region_start
// and region_end through cfg_we_i/cfg_idx_i/cfg_data_i only while the
// block is idle; the block does not enforce it. range_i is ready only in
// the idle state. A range passes the low, overflow and end checks, moves up
// the k stored entries with a larger start, each by one read and one write
// of the entry RAM through one compare of the shared adder (k reaches
// held_count), and is written. A closing beat with no error and at least
// two entries adds a sweep reading each entry and comparing neighbor pairs.
// The status register parts the two sides: a new set may start while a
// status waits, and a second status stalls the block until status_o.ready.
// Reset: count and recorded error clear, the region registers go to zero
// and status_o.valid drops; the RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module region_range_overlap_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rroc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rroc_pkg::DataW-1:0]       cfg_data_i,
  rroc_range_if.sink                       range_i,
  rroc_status_if.source                    status_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHK_LO  = 4'd1;
  localparam logic [3:0] S_CHK_OV  = 4'd2;
  localparam logic [3:0] S_CHK_END = 4'd3;
  localparam logic [3:0] S_SHIFT   = 4'd4;
  localparam logic [3:0] S_INS     = 4'd5;
  localparam logic [3:0] S_DONE    = 4'd6;
  localparam logic [3:0] S_SW0     = 4'd7;
  localparam logic [3:0] S_SW      = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  localparam int unsigned AW = rroc_pkg::AddrW;
  localparam int unsigned CW = rroc_pkg::CountW;
  localparam int unsigned DW = rroc_pkg::DataW;
  localparam int unsigned SW = rroc_pkg::StatusW;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] err_q, err_d;
  logic          out_valid_q, out_valid_d;
  logic [SW-1:0] out_status_q, out_status_d;
  logic [DW-1:0] reg_start_q, reg_end_q;

  logic [DW-1:0] off_q, off_d;
  logic [DW-1:0] len_q, len_d;
  logic          kind_q, kind_d;
  logic          last_q, last_d;
  logic [DW-1:0] lim_q, lim_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [DW-1:0] prev_lim_q, prev_lim_d;
  logic          prev_kind_q, prev_kind_d;
  logic [SW-1:0] res_q, res_d;

  rroc_pkg::alu_op_e  alu_op;
  logic [DW-1:0]      alu_x, alu_y;
  rroc_pkg::alu_res_t alu_res;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  rroc_pkg::entry_t       ram_wdata, ram_rdata;

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] pos_m1, pos_m2, idx_p1;
  logic [CW-1:0] idx_next_cnt;
  logic          out_free;

  // shared adder and entry store
  rroc_alu u_alu (
    .op_i  (alu_op),
    .x_i   (alu_x),
    .y_i   (alu_y),
    .res_o (alu_res)
  );

  rroc_ram #(
    .Width (rroc_pkg::EntryW),
    .Depth (rroc_pkg::MaxRanges)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // address arithmetic
  assign cnt_m1       = cnt_q - CW'(1);
  assign pos_m1       = pos_q - AW'(1);
  assign pos_m2       = pos_q - AW'(2);
  assign idx_p1       = idx_q + AW'(1);
  assign idx_next_cnt = CW'(idx_q) + CW'(1);
  assign out_free     = !out_valid_q || status_o.ready;

  assign range_i.ready   = (state_q == S_IDLE);
  assign status_o.valid  = out_valid_q;
  assign status_o.status = out_status_q;

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    off_d        = off_q;
    len_d        = len_q;
    kind_d       = kind_q;
    last_d       = last_q;
    lim_d        = lim_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    prev_lim_d   = prev_lim_q;
    prev_kind_d  = prev_kind_q;
    res_d        = res_q;
    alu_op       = rroc_pkg::ALU_SUB;
    alu_x        = off_q;
    alu_y        = reg_start_q;
    ram_we       = 1'b0;
    ram_waddr    = pos_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    if (status_o.valid && status_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (range_i.valid) begin
          off_d   = range_i.range_offset;
          len_d   = range_i.range_length;
          kind_d  = range_i.range_kind;
          last_d  = range_i.last_range;
          state_d = S_CHK_LO;
        end
      end
      // offset below region start
      S_CHK_LO: begin
        alu_op = rroc_pkg::ALU_SUB;
        alu_x  = off_q;
        alu_y  = reg_start_q;
        if ((len_q == '0) || (err_q != rroc_pkg::ST_OK)) begin
          state_d = S_DONE;
        end else if (!alu_res.carry) begin
          err_d   = kind_q ? rroc_pkg::ST_FRAME_BELOW : rroc_pkg::ST_SEG_BELOW;
          state_d = S_DONE;
        end else begin
          state_d = S_CHK_OV;
        end
      end
      // end of range overflows 64 bits
      S_CHK_OV: begin
        alu_op = rroc_pkg::ALU_ADD;
        alu_x  = off_q;
        alu_y  = len_q;
        lim_d  = alu_res.sum;
        if (alu_res.carry) begin
          err_d   = kind_q ? rroc_pkg::ST_FRAME_OVFL : rroc_pkg::ST_SEG_OVFL;
          state_d = S_DONE;
        end else begin
          state_d = S_CHK_END;
        end
      end
      // end past region end, then store capacity
      S_CHK_END: begin
        alu_op = rroc_pkg::ALU_SUB;
        alu_x  = reg_end_q;
        alu_y  = lim_q;
        pos_d  = cnt_q[AW-1:0];
        if (!alu_res.carry) begin
          err_d   = kind_q ? rroc_pkg::ST_FRAME_PAST : rroc_pkg::ST_SEG_PAST;
          state_d = S_DONE;
        end else if (cnt_q == CW'(rroc_pkg::MaxRanges)) begin
          err_d   = rroc_pkg::ST_TOO_MANY;
          state_d = S_DONE;
        end else if (cnt_q == '0) begin
          state_d = S_INS;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cnt_m1[AW-1:0];
          state_d   = S_SHIFT;
        end
      end
      // move entries with a larger start up by one
      S_SHIFT: begin
        alu_op = rroc_pkg::ALU_SUB;
        alu_x  = off_q;
        alu_y  = ram_rdata.start;
        if (!alu_res.carry) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q;
          ram_wdata = ram_rdata;
          pos_d     = pos_m1;
          if (pos_q == AW'(1)) begin
            state_d = S_INS;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = pos_m2;
          end
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        ram_we          = 1'b1;
        ram_waddr       = pos_q;
        ram_wdata.start = off_q;
        ram_wdata.lim   = lim_q;
        ram_wdata.kind  = kind_q;
        cnt_d           = cnt_q + CW'(1);
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (err_q != rroc_pkg::ST_OK) begin
          res_d   = err_q;
          state_d = S_OUT;
        end else if (cnt_q < CW'(2)) begin
          res_d   = rroc_pkg::ST_OK;
          state_d = S_OUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_d   = S_SW0;
        end
      end
      // first entry of the sweep
      S_SW0: begin
        prev_lim_d  = ram_rdata.lim;
        prev_kind_d = ram_rdata.kind;
        idx_d       = AW'(1);
        ram_re      = 1'b1;
        ram_raddr   = AW'(1);
        state_d     = S_SW;
      end
      // neighbor overlap: previous end above current start
      S_SW: begin
        alu_op = rroc_pkg::ALU_SUB;
        alu_x  = ram_rdata.start;
        alu_y  = prev_lim_q;
        if (!alu_res.carry) begin
          if (prev_kind_q && ram_rdata.kind) begin
            res_d = rroc_pkg::ST_FRAME_OVERLAP;
          end else if (!prev_kind_q && !ram_rdata.kind) begin
            res_d = rroc_pkg::ST_SEG_OVERLAP;
          end else begin
            res_d = rroc_pkg::ST_MIXED_OVERLAP;
          end
          state_d = S_OUT;
        end else if (idx_next_cnt == cnt_q) begin
          res_d   = rroc_pkg::ST_OK;
          state_d = S_OUT;
        end else begin
          prev_lim_d  = ram_rdata.lim;
          prev_kind_d = ram_rdata.kind;
          idx_d       = idx_p1;
          ram_re      = 1'b1;
          ram_raddr   = idx_p1;
        end
      end
      // hand the status to the output register and close the set
      S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          cnt_d        = '0;
          err_d        = rroc_pkg::ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      err_q       <= rroc_pkg::ST_OK;
      out_valid_q <= 1'b0;
      reg_start_q <= '0;
      reg_end_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == rroc_pkg::REG_REGION_START)) begin
        reg_start_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == rroc_pkg::REG_REGION_END)) begin
        reg_end_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    off_q        <= off_d;
    len_q        <= len_d;
    kind_q       <= kind_d;
    last_q       <= last_d;
    lim_q        <= lim_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    prev_lim_q   <= prev_lim_d;
    prev_kind_q  <= prev_kind_d;
    res_q        <= res_d;
  end

`ifndef SYNTHESIS
  // store never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(rroc_pkg::MaxRanges))
    else $error("range count above store depth");

  // a status load closes the set
  a_out_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (cnt_q == '0 && err_q == rroc_pkg::ST_OK))
    else $error("set state not cleared after status");

  // a shift never reads and writes the same entry
  a_ram_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("entry RAM read and write collide");

  // shifting only runs above entry zero
  a_shift_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (pos_q != '0))
    else $error("shift below entry zero");

  // a held status is not overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_o.valid && !status_o.ready) |=> (status_o.valid && $stable(status_o.status)))
    else $error("pending status lost");
`endif

endmodule
